// File: sv/gnca_pkg.sv
// ----------------------------------------------------------------------------
// gnca_pkg
// Shared types and constants of the grid neighbor count automaton.
// ----------------------------------------------------------------------------
package gnca_pkg;

  localparam int CELL_W  = 6;
  localparam int LIMIT_W = 7;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int STEP_W  = 4;
  localparam int CNT_W   = 4;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_PASS  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BIRTH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERODE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SMOOTH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  localparam logic [CELL_W-1:0]  BG_RESET    = 6'd0;
  localparam logic [CELL_W-1:0]  FG_RESET    = 6'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [CNT_W-1:0] BIRTH_BG_MAX = 4'd2;
  localparam logic [CNT_W-1:0] BIRTH_FG_MIN = 4'd5;
  localparam logic [CNT_W-1:0] ERODE_COUNT  = 4'd5;
  localparam logic [CNT_W-1:0] SMOOTH_MIN   = 4'd3;

  localparam logic [STEP_W-1:0] SELF_STEP = 4'd8;

  localparam logic [1:0] OFS_MINUS = 2'd0;
  localparam logic [1:0] OFS_ZERO  = 2'd1;
  localparam logic [1:0] OFS_PLUS  = 2'd2;

  typedef struct packed {
    logic [1:0] dc;
    logic [1:0] dr;
  } nb_ofs_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              grid_we;
    logic              nxt_we;
    logic [CELL_W-1:0] wr_data;
  } pass_ctl_t;

  function automatic nb_ofs_t nb_offset(input logic [STEP_W-1:0] step);
    nb_ofs_t o;
    case (step)
      4'd0:    o = '{dc: OFS_MINUS, dr: OFS_MINUS};
      4'd1:    o = '{dc: OFS_MINUS, dr: OFS_ZERO};
      4'd2:    o = '{dc: OFS_MINUS, dr: OFS_PLUS};
      4'd3:    o = '{dc: OFS_ZERO,  dr: OFS_MINUS};
      4'd4:    o = '{dc: OFS_ZERO,  dr: OFS_PLUS};
      4'd5:    o = '{dc: OFS_PLUS,  dr: OFS_MINUS};
      4'd6:    o = '{dc: OFS_PLUS,  dr: OFS_ZERO};
      4'd7:    o = '{dc: OFS_PLUS,  dr: OFS_PLUS};
      default: o = '{dc: OFS_ZERO,  dr: OFS_ZERO};
    endcase
    return o;
  endfunction

endpackage

// File: sv/gnca_cell_ram.sv
// ----------------------------------------------------------------------------
// gnca_cell_ram
// Single write port, single registered read port cell memory.
// ----------------------------------------------------------------------------
module gnca_cell_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/gnca_pass_seq.sv
// ----------------------------------------------------------------------------
// gnca_pass_seq
// Pass sequencer: walks the grid, counts foreground neighbors one read per
// cycle through a shared compare and count unit, then updates cells.
// ----------------------------------------------------------------------------
module gnca_pass_seq #(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 32,
  parameter int CW = 7,
  parameter int RW = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gnca_pkg::KIND_W-1:0]   kind,
  input  logic [gnca_pkg::CELL_W-1:0]   bg,
  input  logic [gnca_pkg::CELL_W-1:0]   fg,
  input  logic [gnca_pkg::LIMIT_W-1:0]  limit,
  input  logic [gnca_pkg::CELL_W-1:0]   grid_rdata,
  input  logic [gnca_pkg::CELL_W-1:0]   nxt_rdata,
  output logic [CW+RW-1:0]              grid_rd_addr,
  output logic [CW+RW-1:0]              cell_addr,
  output gnca_pkg::pass_ctl_t           pass_ctl
);

  import gnca_pkg::*;

  localparam logic [2:0] P_IDLE    = 3'd0;
  localparam logic [2:0] P_SCAN    = 3'd1;
  localparam logic [2:0] P_DECIDE  = 3'd2;
  localparam logic [2:0] P_COPY_RD = 3'd3;
  localparam logic [2:0] P_COPY_WR = 3'd4;
  localparam logic [2:0] P_DONE    = 3'd5;

  localparam logic [CW-1:0] COL_FIRST = CW'(2);
  localparam logic [CW-1:0] COL_LAST  = CW'(GRID_COLS - 1);
  localparam logic [RW-1:0] ROW_FIRST = RW'(1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_ROWS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_oob_r, pend_oob_nxt;

  nb_ofs_t           ofs;
  logic [CW:0]       ncol;
  logic [RW:0]       nrow;
  logic              oob;
  logic              hit;
  logic              last_cell;
  logic              clear;
  logic [CW-1:0]     col_adv;
  logic [RW-1:0]     row_adv;

  always_comb begin
    ofs = nb_offset(step_r);
    case (ofs.dc)
      OFS_MINUS: ncol = {1'b0, col_r} - (CW+1)'(1);
      OFS_PLUS:  ncol = {1'b0, col_r} + (CW+1)'(1);
      default:   ncol = {1'b0, col_r};
    endcase
    case (ofs.dr)
      OFS_MINUS: nrow = {1'b0, row_r} - (RW+1)'(1);
      OFS_PLUS:  nrow = {1'b0, row_r} + (RW+1)'(1);
      default:   nrow = {1'b0, row_r};
    endcase
    oob = (ncol >= (CW+1)'(GRID_COLS)) || (nrow >= (RW+1)'(GRID_ROWS));
  end

  assign grid_rd_addr = {ncol[CW-1:0], nrow[RW-1:0]};
  assign cell_addr    = {col_r, row_r};
  assign hit          = pend_r && (pend_oob_r ? (bg == fg) : (grid_rdata == fg));
  assign last_cell    = (col_r == COL_LAST) && (row_r == ROW_LAST);
  assign col_adv      = (row_r == ROW_LAST) ? col_r + CW'(1) : col_r;
  assign row_adv      = (row_r == ROW_LAST) ? ROW_FIRST : row_r + RW'(1);
  assign clear        = (kind_r == KIND_ERODE) ? (count_r == ERODE_COUNT)
                                               : (count_r < SMOOTH_MIN);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    step_nxt     = step_r;
    count_nxt    = count_r + CNT_W'(hit);
    kind_nxt     = kind_r;
    pend_nxt     = 1'b0;
    pend_oob_nxt = 1'b0;
    pass_ctl     = '0;
    pass_ctl.busy = (state_r != P_IDLE);
    unique case (state_r)
      P_IDLE: begin
        count_nxt = '0;
        if (start) begin
          state_nxt = P_SCAN;
          col_nxt   = COL_FIRST;
          row_nxt   = ROW_FIRST;
          step_nxt  = '0;
          kind_nxt  = kind;
        end
      end
      P_SCAN: begin
        pend_nxt     = (step_r != SELF_STEP);
        pend_oob_nxt = oob;
        if (step_r == SELF_STEP) begin
          step_nxt  = '0;
          state_nxt = P_DECIDE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      P_DECIDE: begin
        count_nxt = '0;
        if (kind_r == KIND_BIRTH) begin
          if (count_r <= BIRTH_BG_MAX) begin
            pass_ctl.wr_data = bg;
            pass_ctl.grid_we = ({1'b0, bg} < limit);
          end else if (count_r >= BIRTH_FG_MIN) begin
            pass_ctl.wr_data = fg;
            pass_ctl.grid_we = ({1'b0, fg} < limit);
          end
        end else begin
          pass_ctl.wr_data = clear ? bg : grid_rdata;
          pass_ctl.nxt_we  = 1'b1;
        end
        if (last_cell) begin
          col_nxt   = COL_FIRST;
          row_nxt   = ROW_FIRST;
          state_nxt = (kind_r == KIND_BIRTH) ? P_DONE : P_COPY_RD;
        end else begin
          col_nxt   = col_adv;
          row_nxt   = row_adv;
          state_nxt = P_SCAN;
        end
      end
      P_COPY_RD: begin
        state_nxt = P_COPY_WR;
      end
      P_COPY_WR: begin
        pass_ctl.wr_data = nxt_rdata;
        pass_ctl.grid_we = ({1'b0, nxt_rdata} < limit);
        if (last_cell) begin
          state_nxt = P_DONE;
        end else begin
          col_nxt   = col_adv;
          row_nxt   = row_adv;
          state_nxt = P_COPY_RD;
        end
      end
      P_DONE: begin
        pass_ctl.done = 1'b1;
        state_nxt     = P_IDLE;
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
    end
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    step_r     <= step_nxt;
    kind_r     <= kind_nxt;
    pend_oob_r <= pend_oob_nxt;
  end

endmodule

// File: sv/grid_neighbor_count_automaton.sv
// ----------------------------------------------------------------------------
// grid_neighbor_count_automaton
// Cave smoothing automaton over a grid of cell types with host cell access.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | op, column, grid_row, cell_value,
//          |           |                    | pass_kind
//  out     | output    | out_valid/out_stall| read_value, pass_done
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
//  A read item passes through ST_READ for the registered grid read port.
//  Birth/death pass: one grid read per neighbor through the single grid read
//  port; erode and smooth add a copy back from the buffer to the grid.
//  Synchronous reset clears control state and the config registers, not the grid memories.
//  in_stall is high while an item is at work or a result waits on out_stall.
// ----------------------------------------------------------------------------
module grid_neighbor_count_automaton #(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gnca_pkg::OP_W-1:0]        in_op,
  input  logic [6:0]                       in_column,
  input  logic [4:0]                       in_grid_row,
  input  logic [gnca_pkg::CELL_W-1:0]      in_cell_value,
  input  logic [gnca_pkg::KIND_W-1:0]      in_pass_kind,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gnca_pkg::CELL_W-1:0]      out_read_value,
  output logic                             out_pass_done,
  input  logic                             cfg_wr_en,
  input  logic [gnca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gnca_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import gnca_pkg::*;

  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int AW = CW + RW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PASS = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CELL_W-1:0]  bg_r;
  logic [CELL_W-1:0]  fg_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               rd_inside_r, rd_inside_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  read_value_r, read_value_nxt;
  logic               pass_done_r, pass_done_nxt;

  logic               accept;
  logic               on_grid;
  logic               host_we;
  logic               out_load;
  logic               pass_start;
  logic [AW-1:0]      host_addr;
  logic [AW-1:0]      pass_rd_addr;
  logic [AW-1:0]      cell_addr;
  logic [AW-1:0]      grid_rd_addr;
  logic [AW-1:0]      grid_wr_addr;
  logic [CELL_W-1:0]  grid_wr_data;
  logic               grid_we;
  logic [CELL_W-1:0]  grid_rdata;
  logic [CELL_W-1:0]  nxt_rdata;
  pass_ctl_t          pass_ctl;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign on_grid   = (int'(in_column) < GRID_COLS) && (int'(in_grid_row) < GRID_ROWS);
  assign host_addr = {CW'(in_column), RW'(in_grid_row)};
  assign host_we   = accept && (in_op == OP_WRITE) && on_grid &&
                     ({1'b0, in_cell_value} < limit_r);
  assign pass_start = accept && (in_op == OP_PASS) && (in_pass_kind <= KIND_SMOOTH);

  assign grid_rd_addr = pass_ctl.busy ? pass_rd_addr : host_addr;
  assign grid_wr_addr = pass_ctl.busy ? cell_addr : host_addr;
  assign grid_wr_data = pass_ctl.busy ? pass_ctl.wr_data : in_cell_value;
  assign grid_we      = pass_ctl.busy ? pass_ctl.grid_we : host_we;

  gnca_cell_ram #(
    .ADDR_W (AW),
    .DATA_W (CELL_W)
  ) u_cell_grid (
    .clk     (clk),
    .we      (grid_we),
    .wr_addr (grid_wr_addr),
    .wr_data (grid_wr_data),
    .rd_addr (grid_rd_addr),
    .rd_data (grid_rdata)
  );

  gnca_cell_ram #(
    .ADDR_W (AW),
    .DATA_W (CELL_W)
  ) u_next_grid (
    .clk     (clk),
    .we      (pass_ctl.nxt_we),
    .wr_addr (cell_addr),
    .wr_data (pass_ctl.wr_data),
    .rd_addr (cell_addr),
    .rd_data (nxt_rdata)
  );

  gnca_pass_seq #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CW        (CW),
    .RW        (RW)
  ) u_pass_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (pass_start),
    .kind         (in_pass_kind),
    .bg           (bg_r),
    .fg           (fg_r),
    .limit        (limit_r),
    .grid_rdata   (grid_rdata),
    .nxt_rdata    (nxt_rdata),
    .grid_rd_addr (pass_rd_addr),
    .cell_addr    (cell_addr),
    .pass_ctl     (pass_ctl)
  );

  always_comb begin
    state_nxt      = state_r;
    rd_inside_nxt  = rd_inside_r;
    out_load       = 1'b0;
    read_value_nxt = read_value_r;
    pass_done_nxt  = pass_done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            state_nxt     = ST_READ;
            rd_inside_nxt = on_grid;
          end else if (pass_start) begin
            state_nxt = ST_PASS;
          end else begin
            out_load       = 1'b1;
            read_value_nxt = '0;
            pass_done_nxt  = 1'b0;
          end
        end
      end
      ST_READ: begin
        out_load       = 1'b1;
        read_value_nxt = rd_inside_r ? grid_rdata : bg_r;
        pass_done_nxt  = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_PASS: begin
        if (pass_ctl.done) begin
          out_load       = 1'b1;
          read_value_nxt = '0;
          pass_done_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bg_r        <= BG_RESET;
      fg_r        <= FG_RESET;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BG:    bg_r    <= cfg_wdata[CELL_W-1:0];
          CFG_FG:    fg_r    <= cfg_wdata[CELL_W-1:0];
          CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
    rd_inside_r  <= rd_inside_nxt;
    read_value_r <= read_value_nxt;
    pass_done_r  <= pass_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_value_r;
  assign out_pass_done  = pass_done_r;

`ifndef ASSERT_OFF
  a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    pass_ctl.done |-> (state_r == ST_PASS))
    else $error("pass finished outside a pass item");

  a_no_host_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    pass_ctl.busy |-> !host_we)
    else $error("host write while a pass owns the grid");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled item");

  a_start_leads_pass: assert property (@(posedge clk) disable iff (!rst_n)
    pass_start |=> (pass_ctl.busy && state_r == ST_PASS))
    else $error("pass item did not start the sequencer");
`endif

endmodule
